@@ rtl/mfd_pkg.sv @@
package mfd_pkg;

    // Frame layout
    localparam int unsigned HDR_BYTES   = 14;
    localparam int unsigned HDR_IDX_W   = 4;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned LEN_W       = 16;

    // Header byte offsets
    localparam int unsigned OFS_MAGIC   = 0;
    localparam int unsigned OFS_VERSION = 4;
    localparam int unsigned OFS_COMMAND = 5;
    localparam int unsigned OFS_FLAGS   = 6;
    localparam int unsigned OFS_STATUS  = 7;
    localparam int unsigned OFS_REQ_ID  = 8;
    localparam int unsigned OFS_LENGTH  = 12;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC_WORD  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_MASK   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STATUS  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd3;

    localparam logic [31:0] MAGIC_RST       = 32'd0;
    localparam logic [7:0]  FLAG_MASK_RST   = 8'd128;
    localparam logic [7:0]  MAX_STATUS_RST  = 8'd0;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    typedef enum logic [1:0] {
        ST_NEED_MORE = 2'd0,
        ST_READY     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LARGE = 2'd3
    } decode_status_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  response_flag_mask;
        logic [7:0]  max_status_code;
        logic [15:0] max_payload_bytes;
    } cfg_t;

    typedef struct packed {
        decode_status_t    decode_status;
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [7:0]        frame_version;
        logic [7:0]        frame_command;
        logic [7:0]        frame_flags;
        logic [7:0]        frame_status;
        logic [31:0]       request_tag;
        logic [LEN_W-1:0]  payload_length;
    } result_t;

endpackage

@@ rtl/mfd_core.sv @@
module mfd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  mfd_pkg::cfg_t   cfg,
    output mfd_pkg::result_t result
);

    logic [7:0]                   hdr_reg [mfd_pkg::HDR_BYTES];
    logic [7:0]                   hdr_next [mfd_pkg::HDR_BYTES];
    logic [7:0]                   hdr_cur [mfd_pkg::HDR_BYTES];
    logic [mfd_pkg::COUNT_W-1:0]  count_reg;
    logic [mfd_pkg::COUNT_W-1:0]  count_next;
    logic [mfd_pkg::COUNT_W-1:0]  exp_reg;
    logic [mfd_pkg::COUNT_W-1:0]  exp_next;

    logic                         in_hdr;
    logic [mfd_pkg::HDR_IDX_W-1:0] hdr_idx;
    logic [mfd_pkg::COUNT_W-1:0]  count_inc;
    logic [mfd_pkg::COUNT_W-1:0]  exp_cur;
    logic                         hdr_done;
    logic [31:0]                  magic;
    logic [mfd_pkg::LEN_W-1:0]    length;
    logic                         malformed;
    logic                         too_large;
    logic                         frame_ready;
    logic                         restart;

    assign in_hdr    = count_reg < mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES);
    assign hdr_idx   = count_reg[mfd_pkg::HDR_IDX_W-1:0];
    assign count_inc = count_reg + mfd_pkg::COUNT_W'(1);
    assign hdr_done  = count_inc == mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES);

    // Merge the arriving byte into the header
    always_comb
    begin
        for (int i = 0; i < int'(mfd_pkg::HDR_BYTES); i++)
        begin
            if (in_hdr && hdr_idx == mfd_pkg::HDR_IDX_W'(i))
                hdr_cur[i] = data_byte;
            else
                hdr_cur[i] = hdr_reg[i];
        end
    end

    assign magic  = {hdr_cur[mfd_pkg::OFS_MAGIC+3], hdr_cur[mfd_pkg::OFS_MAGIC+2],
                     hdr_cur[mfd_pkg::OFS_MAGIC+1], hdr_cur[mfd_pkg::OFS_MAGIC]};
    assign length = {hdr_cur[mfd_pkg::OFS_LENGTH+1], hdr_cur[mfd_pkg::OFS_LENGTH]};

    // Check the complete header; malformed wins over too large
    assign malformed = hdr_done &&
                       ((magic != cfg.magic_word) ||
                        ((hdr_cur[mfd_pkg::OFS_FLAGS] & ~cfg.response_flag_mask) != 8'd0) ||
                        (hdr_cur[mfd_pkg::OFS_STATUS] > cfg.max_status_code));
    assign too_large = hdr_done && !malformed && (length > cfg.max_payload_bytes);

    // Total frame length becomes known on the last header byte
    assign exp_cur = (hdr_done && !malformed && !too_large)
                   ? ({1'b0, length} + mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES))
                   : exp_reg;

    assign frame_ready = !malformed && !too_large && (exp_cur != '0) &&
                         (count_inc == exp_cur);
    assign restart     = malformed || too_large || frame_ready;

    // Build the result word
    always_comb
    begin
        result = '0;
        if (malformed)
            result.decode_status = mfd_pkg::ST_MALFORMED;
        else if (too_large)
            result.decode_status = mfd_pkg::ST_TOO_LARGE;
        else if (frame_ready)
            result.decode_status = mfd_pkg::ST_READY;
        else
            result.decode_status = mfd_pkg::ST_NEED_MORE;

        if (!in_hdr)
        begin
            result.payload_valid = 1'b1;
            result.payload_byte  = data_byte;
            result.payload_index = mfd_pkg::LEN_W'(count_reg - mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES));
        end

        if (frame_ready)
        begin
            result.frame_version  = hdr_cur[mfd_pkg::OFS_VERSION];
            result.frame_command  = hdr_cur[mfd_pkg::OFS_COMMAND];
            result.frame_flags    = hdr_cur[mfd_pkg::OFS_FLAGS];
            result.frame_status   = hdr_cur[mfd_pkg::OFS_STATUS];
            result.request_tag    = {hdr_cur[mfd_pkg::OFS_REQ_ID+3], hdr_cur[mfd_pkg::OFS_REQ_ID+2],
                                     hdr_cur[mfd_pkg::OFS_REQ_ID+1], hdr_cur[mfd_pkg::OFS_REQ_ID]};
            result.payload_length = length;
        end
    end

    // Hold frame state without a step; else advance it, or drop it on frame end or a bad header
    always_comb
    begin
        if (!step)
        begin
            hdr_next   = hdr_reg;
            count_next = count_reg;
            exp_next   = exp_reg;
        end
        else if (restart)
        begin
            for (int i = 0; i < int'(mfd_pkg::HDR_BYTES); i++)
                hdr_next[i] = 8'd0;
            count_next = '0;
            exp_next   = '0;
        end
        else
        begin
            hdr_next   = hdr_cur;
            count_next = count_inc;
            exp_next   = exp_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(mfd_pkg::HDR_BYTES); i++)
                hdr_reg[i] <= 8'd0;
            count_reg <= '0;
            exp_reg   <= '0;
        end
        else
        begin
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

`ifndef SYNTHESIS
    a_len_known_in_payload : assert property (@(posedge clk) disable iff (!rst_n)
        exp_reg != '0 |-> count_reg >= mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES) &&
                          count_reg < exp_reg)
        else $error("frame count outside known frame length");

    a_len_unknown_in_header : assert property (@(posedge clk) disable iff (!rst_n)
        exp_reg == '0 |-> count_reg < mfd_pkg::COUNT_W'(mfd_pkg::HDR_BYTES))
        else $error("frame count past header without known length");

    a_restart_clears : assert property (@(posedge clk) disable iff (!rst_n)
        step && result.decode_status != mfd_pkg::ST_NEED_MORE |=>
            count_reg == '0 && exp_reg == '0)
        else $error("frame state not cleared after frame end or bad header");
`endif

endmodule

@@ rtl/message_frame_decoder.sv @@
// Each accepted byte's result word is registered in the output or skid word. Header
// check and counter update are combinational. Throughput: one byte per cycle while
// in_stall is low; a two-entry output buffer keeps input open while a word waits.
// Reset: rst_n is asynchronous, active low; clears frame state, the output
// buffer and loads the configuration registers with their default values.
module message_frame_decoder (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      decode_status,
    output logic                            payload_valid,
    output logic [7:0]                      payload_byte,
    output logic [15:0]                     payload_index,
    output logic [7:0]                      frame_version,
    output logic [7:0]                      frame_command,
    output logic [7:0]                      frame_flags,
    output logic [7:0]                      frame_status,
    output logic [31:0]                     request_tag,
    output logic [15:0]                     payload_length,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mfd_pkg::cfg_t    cfg_reg;
    mfd_pkg::cfg_t    cfg_next;
    mfd_pkg::result_t core_res;
    mfd_pkg::result_t out_reg;
    mfd_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_take;
    logic             out_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mfd_pkg::CFG_MAGIC_WORD:  cfg_next.magic_word         = cfg_data;
                mfd_pkg::CFG_FLAG_MASK:   cfg_next.response_flag_mask = cfg_data[7:0];
                mfd_pkg::CFG_MAX_STATUS:  cfg_next.max_status_code    = cfg_data[7:0];
                mfd_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload_bytes  = cfg_data[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word         <= mfd_pkg::MAGIC_RST;
            cfg_reg.response_flag_mask <= mfd_pkg::FLAG_MASK_RST;
            cfg_reg.max_status_code    <= mfd_pkg::MAX_STATUS_RST;
            cfg_reg.max_payload_bytes  <= mfd_pkg::MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshakes
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    mfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_take),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .result    (core_res)
    );

    // Output word and skid word: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // Output word and skid word: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= core_res;
            else
                skid_reg <= core_res;
        end
        else if (out_take)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign decode_status  = out_reg.decode_status;
    assign payload_valid  = out_reg.payload_valid;
    assign payload_byte   = out_reg.payload_byte;
    assign payload_index  = out_reg.payload_index;
    assign frame_version  = out_reg.frame_version;
    assign frame_command  = out_reg.frame_command;
    assign frame_flags    = out_reg.frame_flags;
    assign frame_status   = out_reg.frame_status;
    assign request_tag    = out_reg.request_tag;
    assign payload_length = out_reg.payload_length;

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_take_gives_word : assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> out_valid_reg)
        else $error("accepted byte produced no output word");

    a_skid_moves_up : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word not moved to output");
`endif

endmodule
